FILE: hdl/pat_pkg.sv
// shared widths, defaults and stage-to-stage control type for the peak and area block
package pat_pkg;

  // fixed field widths on the stream ports
  localparam int TIME_W = 32;
  localparam int CONC_W = 24;
  localparam int AREA_W = 64;

  // packed beat widths, whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 120;

  // default internal widths
  localparam int TIME_BITS_DEF = 32;
  localparam int CONC_BITS_DEF = 24;

  // signed area clamp limits
  localparam logic [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

  // control carried with one area term
  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
  } term_ctrl_t;

endpackage

FILE: hdl/pat_front.sv
// input register, peak and previous-sample tracking, and the area term multiplier
module pat_front #(
  parameter int TIME_BITS = pat_pkg::TIME_BITS_DEF,
  parameter int CONC_BITS = pat_pkg::CONC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pat_pkg::TIME_W-1:0]       in_time,
  input  logic [pat_pkg::CONC_W-1:0]       in_conc,
  input  logic                             in_last,
  output pat_pkg::term_ctrl_t              term,
  input  logic                             term_ready,
  output logic [TIME_BITS+CONC_BITS:0]     term_mag,
  output logic [CONC_BITS-1:0]             term_peak_conc,
  output logic [TIME_BITS-1:0]             term_peak_time
);
  import pat_pkg::*;

  localparam int MAG_W = TIME_BITS + CONC_BITS + 1;

  // input register
  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_time;
  logic [CONC_BITS-1:0] s1_conc;
  logic                 s1_last;
  logic                 s1_adv;

  // per-profile tracking
  logic                 have_previous;
  logic [TIME_BITS-1:0] previous_time;
  logic [CONC_BITS-1:0] previous_conc;
  logic [CONC_BITS-1:0] best_conc;
  logic [TIME_BITS-1:0] best_time;

  logic                 neg;
  logic [TIME_BITS-1:0] dt;
  logic [CONC_BITS:0]   cs;
  logic [MAG_W-1:0]     mag_next;
  logic                 take_peak;
  logic [CONC_BITS-1:0] best_conc_next;
  logic [TIME_BITS-1:0] best_time_next;

  assign s1_adv   = s1_valid && (!term.valid || term_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // bits above the internal widths are dropped here
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_time <= TIME_BITS'(in_time);
      s1_conc <= CONC_BITS'(in_conc);
      s1_last <= in_last;
    end
  end

  always_comb begin
    neg       = s1_time < previous_time;
    dt        = neg ? (previous_time - s1_time) : (s1_time - previous_time);
    cs        = {1'b0, previous_conc} + {1'b0, s1_conc};
    mag_next  = have_previous ? (MAG_W'(dt) * MAG_W'(cs)) : '0;
    // first sample of a profile always sets the peak, ties keep the earlier one
    take_peak = !have_previous || (s1_conc > best_conc);
    best_conc_next = take_peak ? s1_conc : best_conc;
    best_time_next = take_peak ? s1_time : best_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      previous_time <= '0;
      previous_conc <= '0;
      best_conc     <= '0;
      best_time     <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        have_previous <= 1'b0;
        previous_time <= '0;
        previous_conc <= '0;
        best_conc     <= '0;
        best_time     <= '0;
      end else begin
        have_previous <= 1'b1;
        previous_time <= s1_time;
        previous_conc <= s1_conc;
        best_conc     <= best_conc_next;
        best_time     <= best_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term.valid <= 1'b0;
    end else if (!term.valid || term_ready) begin
      term.valid <= s1_valid;
    end
    if (s1_adv) begin
      term.last      <= s1_last;
      term.neg       <= neg;
      term_mag       <= mag_next;
      term_peak_conc <= best_conc_next;
      term_peak_time <= best_time_next;
    end
  end

  // a last sample leaves the tracker empty for the next profile
  assert property (@(posedge clk) disable iff (rst)
    (!rst && s1_adv && s1_last) |=> !have_previous)
    else $error("tracker not cleared after last sample");

  // the first sample of a profile contributes no area
  assert property (@(posedge clk) disable iff (rst)
    (!rst && s1_adv && !have_previous) |=> (term_mag == '0))
    else $error("first sample produced a nonzero area term");

  // a free term stage never holds off the input
  assert property (@(posedge clk) disable iff (rst)
    (!term.valid || term_ready) |-> in_ready)
    else $error("input stalled with the term stage free");

endmodule

FILE: hdl/pat_accum.sv
// saturating area accumulator and result register
module pat_accum #(
  parameter int TIME_BITS = pat_pkg::TIME_BITS_DEF,
  parameter int CONC_BITS = pat_pkg::CONC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pat_pkg::term_ctrl_t           term,
  output logic                          term_ready,
  input  logic [TIME_BITS+CONC_BITS:0]  term_mag,
  input  logic [CONC_BITS-1:0]          term_peak_conc,
  input  logic [TIME_BITS-1:0]          term_peak_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pat_pkg::CONC_W-1:0]    peak_conc,
  output logic [pat_pkg::TIME_W-1:0]    peak_time,
  output logic [pat_pkg::AREA_W-1:0]    area_doubled,
  output logic                          area_saturated
);
  import pat_pkg::*;

  logic              out_free;
  logic              term_adv;
  logic [AREA_W-1:0] area_sum;
  logic              sum_clipped;
  logic [AREA_W:0]   mag_ext;
  logic [AREA_W:0]   addend;
  logic [AREA_W:0]   raw;
  logic              ovf;
  logic [AREA_W-1:0] area_sum_next;
  logic              sum_clipped_next;

  // only a last term needs room in the result register
  assign out_free   = !out_valid || out_ready;
  assign term_ready = !term.last || out_free;
  assign term_adv   = term.valid && term_ready;

  always_comb begin
    mag_ext = (AREA_W+1)'(term_mag);
    addend  = term.neg ? (~mag_ext + 1'b1) : mag_ext;
    raw     = {area_sum[AREA_W-1], area_sum} + addend;
    ovf     = raw[AREA_W] != raw[AREA_W-1];
    if (ovf) begin
      area_sum_next = raw[AREA_W] ? AREA_MIN : AREA_MAX;
    end else begin
      area_sum_next = raw[AREA_W-1:0];
    end
    sum_clipped_next = sum_clipped || ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_sum    <= '0;
      sum_clipped <= 1'b0;
    end else if (term_adv) begin
      if (term.last) begin
        area_sum    <= '0;
        sum_clipped <= 1'b0;
      end else begin
        area_sum    <= area_sum_next;
        sum_clipped <= sum_clipped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (term_adv && term.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_adv && term.last) begin
      peak_conc      <= CONC_W'(term_peak_conc);
      peak_time      <= TIME_W'(term_peak_time);
      area_doubled   <= area_sum_next;
      area_saturated <= sum_clipped_next;
    end
  end

  // a last term always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    (!rst && term_adv && term.last) |=> out_valid)
    else $error("last term did not produce a result");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (term.valid && term.last && out_valid && !out_ready) |-> !term_ready)
    else $error("result register overrun");

  // the sum starts clean for the next profile
  assert property (@(posedge clk) disable iff (rst)
    (!rst && term_adv && term.last) |=> (area_sum == '0 && !sum_clipped))
    else $error("area sum not cleared after result");

endmodule

FILE: hdl/peak_and_trapezoid_area.sv
// top level: peak concentration, peak time and doubled trapezoid area per profile
//
// usage
//   s_* carries one sample per beat: time, concentration, and tlast on the
//   final sample of a profile. m_* carries one result beat per profile:
//   peak concentration, time of its first occurrence, twice the trapezoid
//   area (signed, clamped) and in tuser a flag that the clamp was hit.
// throughput
//   one sample per cycle while s_tready is high; peak compare and 32 by 25 bit
//   area term multiply sit in one stage, the saturating accumulate in the next
// result path
//   the last sample of a profile passes the input register, the term register
//   and the result register, in that order, before its result beat shows on m_tvalid
// reset
//   rst empties the pipeline and clears the peak, previous sample and sum
// stall
//   samples without tlast keep draining into the sum while a result waits;
//   a second last sample holds in the term stage until the result is taken,
//   then the input side backs up and s_tready drops
module peak_and_trapezoid_area #(
  parameter int TIME_BITS = pat_pkg::TIME_BITS_DEF,
  parameter int CONC_BITS = pat_pkg::CONC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_time [31:0], sample_conc [55:32]
  input  logic [pat_pkg::IN_DATA_W-1:0]     s_tdata,
  // last_sample
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // peak_conc [23:0], peak_time [55:24], area_doubled [119:56]
  output logic [pat_pkg::OUT_DATA_W-1:0]    m_tdata,
  // area_saturated
  output logic                              m_tuser
);
  import pat_pkg::*;

  term_ctrl_t               term;
  logic                     term_ready;
  logic [TIME_BITS+CONC_BITS:0] term_mag;
  logic [CONC_BITS-1:0]     term_peak_conc;
  logic [TIME_BITS-1:0]     term_peak_time;

  logic [CONC_W-1:0]        peak_conc;
  logic [TIME_W-1:0]        peak_time;
  logic [AREA_W-1:0]        area_doubled;

  // peak tracking and area term
  pat_front #(
    .TIME_BITS (TIME_BITS),
    .CONC_BITS (CONC_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_time        (s_tdata[TIME_W-1:0]),
    .in_conc        (s_tdata[TIME_W+CONC_W-1:TIME_W]),
    .in_last        (s_tlast),
    .term           (term),
    .term_ready     (term_ready),
    .term_mag       (term_mag),
    .term_peak_conc (term_peak_conc),
    .term_peak_time (term_peak_time)
  );

  // clamped sum and result beat
  pat_accum #(
    .TIME_BITS (TIME_BITS),
    .CONC_BITS (CONC_BITS)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .term           (term),
    .term_ready     (term_ready),
    .term_mag       (term_mag),
    .term_peak_conc (term_peak_conc),
    .term_peak_time (term_peak_time),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .peak_conc      (peak_conc),
    .peak_time      (peak_time),
    .area_doubled   (area_doubled),
    .area_saturated (m_tuser)
  );

  // fields packed from the lowest bit up, exactly 15 bytes
  assign m_tdata = {area_doubled, peak_time, peak_conc};

endmodule

FILE: tb/sv/tb_top.sv
// testbench for peak_and_trapezoid_area: random profiles, a built-in predictor and a result scoreboard
module tb_top;
  import pat_pkg::*;

  // one expected result beat per profile
  typedef struct {
    bit [CONC_W-1:0] peak_conc;
    bit [TIME_W-1:0] peak_tick;
    bit [AREA_W-1:0] area;
    bit              clamped;
  } profile_result_t;

  // ------------------------------------------------------------------
  // scoreboard: follows each accepted sample with its own copy of the
  // profile state and queues one expected result per last sample
  // ------------------------------------------------------------------
  class area_scoreboard;
    bit                   have_prev;
    bit [TIME_W-1:0]      prev_tick;
    bit [CONC_W-1:0]      prev_conc;
    bit [CONC_W-1:0]      best_conc;
    bit [TIME_W-1:0]      best_tick;
    longint               area_sum;
    bit                   clamped;
    profile_result_t      pending[$];
    int unsigned          errors;

    function void clear_profile();
      have_prev = 1'b0;
      prev_tick = '0;
      prev_conc = '0;
      best_conc = '0;
      best_tick = '0;
      area_sum  = 0;
      clamped   = 1'b0;
    endfunction

    function new();
      clear_profile();
      errors = 0;
    endfunction

    function void note_sample(bit [TIME_W-1:0] tick, bit [CONC_W-1:0] conc, bit last);
      bit                   neg;
      bit [TIME_W-1:0]      dt;
      bit [CONC_W:0]        conc_sum;
      longint               mag;
      logic signed [AREA_W:0] wide;
      profile_result_t      res;
      if (!have_prev) begin
        // first sample of a profile always sets the peak, even at zero
        best_conc = conc;
        best_tick = tick;
      end else begin
        // time going backward gives a negative term
        neg      = tick < prev_tick;
        dt       = neg ? prev_tick - tick : tick - prev_tick;
        conc_sum = {1'b0, prev_conc} + {1'b0, conc};
        mag      = longint'(dt) * longint'(conc_sum);
        wide     = (AREA_W+1)'(area_sum);
        wide     = neg ? wide - (AREA_W+1)'(mag) : wide + (AREA_W+1)'(mag);
        // a carry into the extra bit means the 64-bit range was left
        if (wide[AREA_W] != wide[AREA_W-1]) begin
          area_sum = wide[AREA_W] ? AREA_MIN : AREA_MAX;
          clamped  = 1'b1;
        end else begin
          area_sum = wide[AREA_W-1:0];
        end
        // strict compare so a tie keeps the earlier sample
        if (conc > best_conc) begin
          best_conc = conc;
          best_tick = tick;
        end
      end
      have_prev = 1'b1;
      prev_tick = tick;
      prev_conc = conc;
      if (last) begin
        res.peak_conc = best_conc;
        res.peak_tick = best_tick;
        res.area      = area_sum;
        res.clamped   = clamped;
        pending.push_back(res);
        clear_profile();
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(bit [CONC_W-1:0] pc, bit [TIME_W-1:0] pt, bit [AREA_W-1:0] area,
                      bit sat);
      profile_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat with no profile waiting (peak %h area %h)", pc, area));
        return;
      end
      want = pending.pop_front();
      if (pc != want.peak_conc)
        report($sformatf("peak_conc got %h want %h", pc, want.peak_conc));
      if (pt != want.peak_tick)
        report($sformatf("peak_time got %h want %h", pt, want.peak_tick));
      if (area != want.area)
        report($sformatf("area_doubled got %h want %h", area, want.area));
      if (sat != want.clamped)
        report($sformatf("area_saturated got %b want %b", sat, want.clamped));
    endtask
  endclass

  // ------------------------------------------------------------------
  // clock, reset and block ports
  // ------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  always #2 clk = ~clk;

  peak_and_trapezoid_area u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // sample_time [31:0], sample_conc [55:32]
    .s_tlast  (s_tlast),  // last_sample
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),  // peak_conc [23:0], peak_time [55:24], area_doubled [119:56]
    .m_tuser  (m_tuser)   // area_saturated
  );

  area_scoreboard sb;

  // idle percentages picked per stretch of the run; zero gives busy stretches
  localparam int unsigned IDLE_PCT [3] = '{0, 15, 40};
  localparam int unsigned RANDOM_SAMPLES = 250;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam bit [CONC_W-1:0] CONC_FULL = '1;
  localparam bit [TIME_W-1:0] TICK_FULL = '1;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          no_idle   = 1'b0;
  int unsigned samples_sent = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  // ------------------------------------------------------------------
  // monitor: both handshakes are sampled at the rising edge
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_sample(s_tdata[TIME_W-1:0], s_tdata[TIME_W +: CONC_W], s_tlast);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[CONC_W-1:0], m_tdata[CONC_W +: TIME_W],
                      m_tdata[CONC_W+TIME_W +: AREA_W], m_tuser);
  end

  // watchdog: a run that stops moving beats is a failure
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL peak_and_trapezoid_area");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: ready drops in bursts at random, as often as stall_pct sets
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(99, 0) < stall_pct) begin
      stall_left = $urandom_range(9, 1) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // sample side
  // ------------------------------------------------------------------

  // drives one sample beat from a falling edge, optionally after a gap,
  // and returns at the rising edge that takes it
  task automatic send_sample(bit [TIME_W-1:0] tick, bit [CONC_W-1:0] conc, bit last);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(99, 0) < gap_pct) ? $urandom_range(9, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {conc, tick};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic bit [TIME_W-1:0] pick_step();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return $urandom_range(16, 1);
      2:       return $urandom_range(65535, 1);
      default: return $urandom & 32'h0FFF_FFFF;
    endcase
  endfunction

  function automatic bit [CONC_W-1:0] pick_conc(bit [CONC_W-1:0] prev);
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return CONC_FULL;
      2:       return prev;  // repeats make peak ties
      3:       return CONC_W'($urandom_range(255, 0));
      default: return CONC_W'($urandom);
    endcase
  endfunction

  // mostly time-ordered profiles of random length; a few have scrambled
  // times, and some wrap past the top of the time range
  task automatic send_random_profile();
    int unsigned     len;
    int unsigned     i;
    bit              noisy;
    bit [TIME_W-1:0] tick;
    bit [CONC_W-1:0] conc;
    noisy = ($urandom_range(9, 0) == 0);
    len   = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    tick  = ($urandom_range(3, 0) == 0) ? '0 : $urandom;
    conc  = '0;
    for (i = 0; i < len; i++) begin
      if (i != 0)
        tick = noisy ? $urandom : tick + pick_step();
      conc = pick_conc(conc);
      send_sample(tick, conc, i == len - 1);
    end
  endtask

  // drives the sum into its clamp: each round moves time across the whole
  // range at nearly full concentration one way, and back at zero
  // concentration the other way; then one more term the same way and one opposite term follow the clamp
  task automatic send_clamp_profile(bit upward);
    int unsigned     i;
    bit [TIME_W-1:0] lo, hi;
    bit [CONC_W-1:0] c0, c1;
    for (i = 0; i < 70; i++) begin
      lo = $urandom_range(255, 0);
      hi = TICK_FULL - $urandom_range(255, 0);
      c0 = CONC_FULL - CONC_W'($urandom_range(255, 0));
      c1 = CONC_FULL - CONC_W'($urandom_range(255, 0));
      send_sample(upward ? lo : hi, c0, 1'b0);
      send_sample(upward ? hi : lo, c1, 1'b0);
      send_sample(upward ? hi : lo, '0, 1'b0);
      send_sample(upward ? $urandom_range(255, 0) : TICK_FULL - $urandom_range(255, 0),
                  '0, 1'b0);
    end
    c0 = CONC_W'($urandom);
    send_sample(upward ? TICK_FULL : '0, c0, 1'b0);
    send_sample(upward ? '0 : TICK_FULL, CONC_W'($urandom), 1'b1);
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    int unsigned random_base;
    int unsigned repick_at;
    bit          clamp_done;
    sb = new();
    clamp_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single-sample profiles at both extremes, zero peak first
    send_sample('0, '0, 1'b1);
    send_sample(TICK_FULL, CONC_FULL, 1'b1);
    // peak ties keep the earlier sample, one step runs backward in time
    send_sample(32'd10, 24'd5, 1'b0);
    send_sample(32'd20, 24'd5, 1'b0);
    send_sample(32'd30, 24'd3, 1'b0);
    send_sample(32'd25, 24'd7, 1'b0);
    send_sample(32'd40, 24'd7, 1'b1);
    // all-zero concentration keeps the first sample as the peak
    send_sample(32'd100, '0, 1'b0);
    send_sample(32'd200, '0, 1'b0);
    send_sample(32'd300, '0, 1'b1);
    // largest single positive and negative terms
    send_sample('0, CONC_FULL, 1'b0);
    send_sample(TICK_FULL, CONC_FULL, 1'b1);
    send_sample(TICK_FULL, CONC_FULL, 1'b0);
    send_sample('0, CONC_FULL, 1'b1);
    // repeated time gives a zero term
    send_sample(32'd5, 24'd9, 1'b0);
    send_sample(32'd5, 24'd9, 1'b1);

    // random part; idling is repicked after 40 samples or more, none near the end;
    // one clamp profile, upper or lower limit at random
    random_base = samples_sent;
    repick_at   = samples_sent;
    while (samples_sent - random_base < RANDOM_SAMPLES) begin
      if (samples_sent >= repick_at) begin
        gap_pct   = IDLE_PCT[$urandom_range(2, 0)];
        stall_pct = IDLE_PCT[$urandom_range(2, 0)];
        repick_at = samples_sent + 40;
      end
      if (samples_sent - random_base >= RANDOM_SAMPLES - 80)
        no_idle = 1'b1;
      if (!clamp_done && samples_sent - random_base >= 100) begin
        send_clamp_profile(1'($urandom_range(1, 0)));
        clamp_done  = 1'b1;
        random_base = random_base + 282;
      end else begin
        send_random_profile();
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // drain, then keep the clock running to catch a stray result beat
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS peak_and_trapezoid_area");
    else
      $display("FAIL peak_and_trapezoid_area");
    $finish;
  end

endmodule

FILE: files.f
hdl/pat_pkg.sv
hdl/pat_front.sv
hdl/pat_accum.sv
hdl/peak_and_trapezoid_area.sv
tb/sv/tb_top.sv
